[src/bitmap_page_frame_allocator_assert.svh]
// Assertion macros for the bitmap page frame allocator checker.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfa: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfa: same-cycle check failed");

`endif

[src/bfa_pkg.sv]
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; used by every module of the block but bfa_ram.
package bfa_pkg;

	localparam int unsigned PAGES_DEF = 4096;
	localparam int WORD_W = 32;
	localparam int BIT_W = 5;
	localparam int CNT_W = 13;
	localparam int RUN_W = 14;
	localparam int IDX_W = 12;
	localparam int ACT_W = 3;
	localparam int STS_W = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FREE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_LOCK = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESERVE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_UNRESERVE = 3'd4;

	localparam logic [STS_W-1:0] STS_OK = 2'd0;
	localparam logic [STS_W-1:0] STS_NOFIT = 2'd1;
	localparam logic [STS_W-1:0] STS_BAD = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] page_index;
		logic [CNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] found_page;
		logic [CNT_W-1:0] free_pages;
		logic [CNT_W-1:0] used_pages;
		logic [CNT_W-1:0] reserved_pages;
	} rsp_t;

	// Control into the word unit: bit window of the current word and update sense.
	typedef struct packed {
		logic set;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} wu_ctl_t;

	// Word unit results for both the run search and the range update.
	typedef struct packed {
		logic hit;
		logic [BIT_W-1:0] hit_bit;
		logic [CNT_W-1:0] carry_out;
		logic [WORD_W-1:0] new_word;
		logic [BIT_W:0] n_changed;
		logic any_changed;
		logic [BIT_W-1:0] low_bit;
	} wu_res_t;

endpackage

[src/bfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/bfa_word_unit.sv]
// Shared word unit: free-run search and range set/clear over one 32-bit map word.
// Depends on bfa_pkg.
module bfa_word_unit (
	input  bfa_pkg::wu_ctl_t ctl,
	input  logic [bfa_pkg::WORD_W-1:0] word,
	input  logic [bfa_pkg::CNT_W-1:0] carry,
	input  logic [bfa_pkg::CNT_W-1:0] need,
	output bfa_pkg::wu_res_t res
);
	import bfa_pkg::*;

	logic [WORD_W-1:0] eb;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] chg;
	logic [WORD_W-1:0] hit_v;
	logic found_b;
	logic [BIT_W-1:0] lb;
	logic [RUN_W-1:0] run;

	// Bits outside the window count as busy for the search.
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			mask[k] = (BIT_W'(k) >= ctl.lo) && (BIT_W'(k) <= ctl.hi);
			eb[k] = word[k] | ~mask[k];
		end
	end

	// Run length ending at each bit: from the last busy bit below it, else carried in.
	always_comb begin
		found_b = 1'b0;
		lb = '0;
		run = '0;
		for (int k = 0; k < WORD_W; k++) begin
			found_b = 1'b0;
			lb = '0;
			for (int j = 0; j < WORD_W; j++) begin
				if ((j <= k) && eb[j]) begin
					found_b = 1'b1;
					lb = BIT_W'(j);
				end
			end
			if (found_b) begin
				run = RUN_W'(BIT_W'(k) - lb);
			end else begin
				run = RUN_W'(carry) + RUN_W'(k + 1);
			end
			hit_v[k] = (run >= RUN_W'(need));
		end
	end

	always_comb begin
		res.hit = |hit_v;
		res.hit_bit = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (hit_v[k]) begin
				res.hit_bit = BIT_W'(k);
			end
		end
		// found_b and lb hold the top bit's view after the search loop
		if (found_b) begin
			res.carry_out = CNT_W'(BIT_W'(WORD_W - 1) - lb);
		end else begin
			res.carry_out = CNT_W'(RUN_W'(carry) + RUN_W'(WORD_W));
		end
	end

	always_comb begin
		chg = ctl.set ? (~word & mask) : (word & mask);
		res.new_word = ctl.set ? (word | chg) : (word & ~chg);
		res.any_changed = |chg;
		res.n_changed = '0;
		res.low_bit = '0;
		for (int k = 0; k < WORD_W; k++) begin
			res.n_changed = res.n_changed + (BIT_W + 1)'(chg[k]);
		end
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (chg[k]) begin
				res.low_bit = BIT_W'(k);
			end
		end
	end

endmodule

[src/bitmap_page_frame_allocator.sv]
// Channel | Signals                     | Moves
// req     | req_valid, req_stall, req   | one request: action, page_index, page_count
// rsp     | rsp_valid, rsp_stall, rsp   | one response per request: status, counts
//
// The map sits in a RAM of 32-bit words; one word unit serves every word in turn.
// An allocate scans the map word by word from the hint, then marks each word of the run;
// a failed scan goes on to S_DONE. Free, lock, reserve and unreserve update each word of
// the range. Rejected requests, and an allocate with the hint at the end, go straight
// to S_DONE. After reset a clearing pass zeroes every map word with req_stall high.
// A waiting response holds the next one in S_DONE until it is taken.
// Depends on bfa_pkg, bfa_ram and bfa_word_unit.
module bitmap_page_frame_allocator #(
	parameter int unsigned PAGES = bfa_pkg::PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  bfa_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output bfa_pkg::rsp_t rsp
);
	import bfa_pkg::*;

	localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW = $clog2(PAGES);
	localparam int CW = $clog2(PAGES + 1);
	localparam int CW1 = CW + 1;
	localparam int XW = ((CW > CNT_W) ? CW : CNT_W) + 1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_RANGE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic issue_q, issue_d;
	logic vld_s1, vld_d;
	logic ovalid_q, ovalid_d;
	logic [AW-1:0] rd_w_q, rd_w_d;
	logic [CW-1:0] hint_q, hint_d;
	logic [CW-1:0] free_q, free_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] resv_q, resv_d;

	logic [PW-1:0] first_q, first_d;
	logic [PW-1:0] last_q, last_d;
	logic [CNT_W-1:0] need_q, need_d;
	logic set_q, set_d;
	logic to_res_q, to_res_d;
	logic [CNT_W-1:0] carry_q, carry_d;
	logic [AW-1:0] w_s1, w_d;
	logic [STS_W-1:0] status_q, status_d;
	logic [PW-1:0] found_q, found_d;
	rsp_t out_q, out_d;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	wu_ctl_t wu_ctl;
	wu_res_t wu_res;

	logic [AW-1:0] fw;
	logic [AW-1:0] lw;
	logic [PW-1:0] alloc_end;
	logic [XW-1:0] alloc_start_x;
	logic [PW-1:0] alloc_start;
	logic [XW-1:0] range_end_x;
	logic [CW-1:0] n_c;
	logic [CW1-1:0] free_sum;
	logic [CW1-1:0] tgt_sum;
	logic [CW-1:0] tgt_q;
	logic [CW-1:0] free_dec, free_inc, tgt_dec, tgt_inc;
	logic [CW-1:0] chg_page;

	bfa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_w_q),
		.rdata(ram_rdata)
	);

	bfa_word_unit u_wu (
		.ctl(wu_ctl),
		.word(ram_rdata),
		.carry(carry_q),
		.need(need_q),
		.res(wu_res)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = ovalid_q;
	assign rsp = out_q;

	always_comb begin
		fw = AW'(first_q >> BIT_W);
		lw = AW'(last_q >> BIT_W);
		wu_ctl.set = set_q;
		wu_ctl.lo = (w_s1 == fw) ? BIT_W'(first_q) : '0;
		wu_ctl.hi = (w_s1 == lw) ? BIT_W'(last_q) : '1;
	end

	// Run position and saturating counter arithmetic for the current word.
	always_comb begin
		alloc_end = PW'({w_s1, wu_res.hit_bit});
		alloc_start_x = XW'(alloc_end) - XW'(need_q) + XW'(1);
		alloc_start = PW'(alloc_start_x);
		range_end_x = XW'(req.page_index) + XW'(req.page_count);
		n_c = CW'(wu_res.n_changed);
		tgt_q = to_res_q ? resv_q : used_q;
		free_dec = (free_q >= n_c) ? (free_q - n_c) : '0;
		tgt_dec = (tgt_q >= n_c) ? (tgt_q - n_c) : '0;
		free_sum = CW1'(free_q) + CW1'(n_c);
		tgt_sum = CW1'(tgt_q) + CW1'(n_c);
		free_inc = (free_sum > CW1'(PAGES)) ? CW'(PAGES) : CW'(free_sum);
		tgt_inc = (tgt_sum > CW1'(PAGES)) ? CW'(PAGES) : CW'(tgt_sum);
		chg_page = CW'({w_s1, wu_res.low_bit});
	end

	always_comb begin
		state_d = state_q;
		issue_d = issue_q;
		vld_d = 1'b0;
		rd_w_d = rd_w_q;
		hint_d = hint_q;
		free_d = free_q;
		used_d = used_q;
		resv_d = resv_q;
		first_d = first_q;
		last_d = last_q;
		need_d = need_q;
		set_d = set_q;
		to_res_d = to_res_q;
		carry_d = carry_q;
		w_d = w_s1;
		status_d = status_q;
		found_d = found_q;
		out_d = out_q;
		ovalid_d = ovalid_q;
		ram_we = 1'b0;
		ram_waddr = w_s1;
		ram_wdata = wu_res.new_word;

		if (ovalid_q && !rsp_stall) begin
			ovalid_d = 1'b0;
		end

		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = rd_w_q;
				ram_wdata = '0;
				if (rd_w_q == AW'(WORDS - 1)) begin
					rd_w_d = '0;
					state_d = S_IDLE;
				end else begin
					rd_w_d = rd_w_q + AW'(1);
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					found_d = '0;
					need_d = req.page_count;
					carry_d = '0;
					if (req.page_count == '0 || req.action > ACT_UNRESERVE) begin
						status_d = STS_BAD;
						state_d = S_DONE;
					end else if (req.action == ACT_ALLOC) begin
						if (hint_q == CW'(PAGES)) begin
							status_d = STS_NOFIT;
							state_d = S_DONE;
						end else begin
							first_d = PW'(hint_q);
							last_d = PW'(PAGES - 1);
							rd_w_d = AW'(hint_q >> BIT_W);
							issue_d = 1'b1;
							state_d = S_SCAN;
						end
					end else if (range_end_x > XW'(PAGES)) begin
						status_d = STS_BAD;
						state_d = S_DONE;
					end else begin
						first_d = PW'(req.page_index);
						last_d = PW'(range_end_x - XW'(1));
						rd_w_d = AW'(req.page_index >> BIT_W);
						issue_d = 1'b1;
						set_d = (req.action == ACT_LOCK) || (req.action == ACT_RESERVE);
						to_res_d = (req.action == ACT_RESERVE) ||
							(req.action == ACT_UNRESERVE);
						status_d = STS_OK;
						state_d = S_RANGE;
					end
				end
			end
			S_SCAN, S_RANGE: begin
				// stream one word read per cycle up to the last word of the window
				vld_d = issue_q;
				w_d = rd_w_q;
				if (issue_q) begin
					if (rd_w_q == lw) begin
						issue_d = 1'b0;
					end else begin
						rd_w_d = rd_w_q + AW'(1);
					end
				end
				if (vld_s1 && state_q == S_SCAN) begin
					if (wu_res.hit) begin
						// mark the run as a lock of its pages; drop the read in flight
						first_d = alloc_start;
						last_d = alloc_end;
						rd_w_d = AW'(alloc_start >> BIT_W);
						issue_d = 1'b1;
						vld_d = 1'b0;
						set_d = 1'b1;
						to_res_d = 1'b0;
						found_d = alloc_start;
						status_d = STS_OK;
						hint_d = CW'(alloc_end);
						state_d = S_RANGE;
					end else begin
						carry_d = wu_res.carry_out;
						if (w_s1 == lw) begin
							hint_d = CW'(PAGES);
							status_d = STS_NOFIT;
							issue_d = 1'b0;
							vld_d = 1'b0;
							state_d = S_DONE;
						end
					end
				end
				if (vld_s1 && state_q == S_RANGE) begin
					ram_we = 1'b1;
					if (set_q) begin
						free_d = free_dec;
						if (to_res_q) begin
							resv_d = tgt_inc;
						end else begin
							used_d = tgt_inc;
						end
					end else begin
						free_d = free_inc;
						if (to_res_q) begin
							resv_d = tgt_dec;
						end else begin
							used_d = tgt_dec;
						end
						if (wu_res.any_changed && chg_page < hint_q) begin
							hint_d = chg_page;
						end
					end
					if (w_s1 == lw) begin
						issue_d = 1'b0;
						vld_d = 1'b0;
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!ovalid_q || !rsp_stall) begin
					out_d.status = status_q;
					out_d.found_page = IDX_W'(found_q);
					out_d.free_pages = CNT_W'(free_q);
					out_d.used_pages = CNT_W'(used_q);
					out_d.reserved_pages = CNT_W'(resv_q);
					ovalid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			issue_q <= 1'b0;
			vld_s1 <= 1'b0;
			ovalid_q <= 1'b0;
			rd_w_q <= '0;
			hint_q <= '0;
			free_q <= CW'(PAGES);
			used_q <= '0;
			resv_q <= '0;
		end else begin
			state_q <= state_d;
			issue_q <= issue_d;
			vld_s1 <= vld_d;
			ovalid_q <= ovalid_d;
			rd_w_q <= rd_w_d;
			hint_q <= hint_d;
			free_q <= free_d;
			used_q <= used_d;
			resv_q <= resv_d;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		last_q <= last_d;
		need_q <= need_d;
		set_q <= set_d;
		to_res_q <= to_res_d;
		carry_q <= carry_d;
		w_s1 <= w_d;
		status_q <= status_d;
		found_q <= found_d;
		out_q <= out_d;
	end

endmodule

[src/bfa_chk.sv]
// Port-level checker for the bitmap page frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_page_frame_allocator_assert.svh.
`include "bitmap_page_frame_allocator_assert.svh"

module bfa_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input bfa_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input bfa_pkg::rsp_t rsp
);
	import bfa_pkg::*;

	// A held response keeps its payload.
	`BFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// The block is busy on the cycle after taking a request.
	`BFA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// Only a successful allocate names a page.
	`BFA_ASSERT_SAME(a_found_zero, rsp_valid && rsp.status != STS_OK, rsp.found_page == '0)

	// The free count never exceeds the map size of the default build.
	`BFA_ASSERT_SAME(a_free_range, rsp_valid, rsp.free_pages <= 13'(PAGES_DEF))

endmodule

bind bitmap_page_frame_allocator bfa_chk u_bfa_chk (.*);

[sim/page_map_checker.sv]
// Page map checker: watches both channels of the page frame allocator, predicts each
// response from its own copy of the busy map, hint and page counts, and compares.
// Depends on bfa_pkg.
module page_map_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  bfa_pkg::req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  bfa_pkg::rsp_t rsp,
	output int   failures,
	output int   pending
);
	import bfa_pkg::*;

	localparam int unsigned NPAGES = PAGES_DEF;

	bit [NPAGES-1:0] frame_busy;
	int unsigned hint;
	int unsigned free_cnt;
	int unsigned used_cnt;
	int unsigned rsvd_cnt;

	rsp_t awaited_rsp[$];
	rsp_t want;
	int mismatches = 0;
	int awaited_cnt = 0;

	assign failures = mismatches;
	assign pending = awaited_cnt;

	function automatic void mark_page(input int unsigned p, input bit to_rsvd);
		if (frame_busy[p])
			return;
		frame_busy[p] = 1'b1;
		if (free_cnt > 0)
			free_cnt--;
		if (to_rsvd) begin
			if (rsvd_cnt < NPAGES)
				rsvd_cnt++;
		end else if (used_cnt < NPAGES) begin
			used_cnt++;
		end
	endfunction

	// The busy bit carries no owner, so the count taken from is the action's, not the page's.
	function automatic void release_page(input int unsigned p, input bit from_rsvd);
		if (!frame_busy[p])
			return;
		frame_busy[p] = 1'b0;
		if (free_cnt < NPAGES)
			free_cnt++;
		if (from_rsvd) begin
			if (rsvd_cnt > 0)
				rsvd_cnt--;
		end else if (used_cnt > 0) begin
			used_cnt--;
		end
		if (hint > p)
			hint = p;
	endfunction

	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		int unsigned cnt;
		int unsigned first;
		int unsigned remaining;
		int unsigned start;
		o = '0;
		o.status = STS_BAD;
		cnt = 32'(r.page_count);
		first = 32'(r.page_index);
		if (cnt == 0 || r.action > ACT_UNRESERVE) begin
			o.status = STS_BAD;
		end else if (r.action == ACT_ALLOC) begin
			// Next fit: a failed scan leaves the hint at the end of the map.
			o.status = STS_NOFIT;
			remaining = cnt;
			start = hint;
			while (hint < NPAGES) begin
				if (!frame_busy[hint]) begin
					remaining--;
					if (remaining == 0) begin
						for (int unsigned i = 0; i < cnt; i++)
							mark_page(start + i, 1'b0);
						o.found_page = IDX_W'(start);
						o.status = STS_OK;
						break;
					end
				end else begin
					remaining = cnt;
					start = hint + 1;
				end
				hint++;
			end
		end else if (first + cnt > NPAGES) begin
			o.status = STS_BAD;
		end else begin
			for (int unsigned i = 0; i < cnt; i++) begin
				case (r.action)
					ACT_FREE: release_page(first + i, 1'b0);
					ACT_LOCK: mark_page(first + i, 1'b0);
					ACT_RESERVE: mark_page(first + i, 1'b1);
					ACT_UNRESERVE: release_page(first + i, 1'b1);
					default: ;
				endcase
			end
			o.status = STS_OK;
		end
		o.free_pages = CNT_W'(free_cnt);
		o.used_pages = CNT_W'(used_cnt);
		o.reserved_pages = CNT_W'(rsvd_cnt);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_busy = '0;
			hint = 0;
			free_cnt = NPAGES;
			used_cnt = 0;
			rsvd_cnt = 0;
			awaited_rsp.delete();
			awaited_cnt <= 0;
		end else begin
			// Retire the response before queueing the request taken at the same edge.
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response: status %0d page %0d free %0d",
							rsp.status, rsp.found_page, rsp.free_pages);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status || rsp.found_page !== want.found_page ||
						rsp.free_pages !== want.free_pages ||
						rsp.used_pages !== want.used_pages ||
						rsp.reserved_pages !== want.reserved_pages) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected status %0d page %0d free %0d ",
								"used %0d reserved %0d, got status %0d page %0d free %0d ",
								"used %0d reserved %0d"},
								want.status, want.found_page, want.free_pages,
								want.used_pages, want.reserved_pages,
								rsp.status, rsp.found_page, rsp.free_pages,
								rsp.used_pages, rsp.reserved_pages);
					end
				end
			end
			if (req_valid && !req_stall)
				awaited_rsp.push_back(apply_request(req));
			awaited_cnt <= awaited_rsp.size();
		end
	end

endmodule

[sim/testbench.sv]
// Testbench top for the bitmap page frame allocator: clock, reset, request stimulus
// with random idling and response stalls, and the verdict.
// Depends on bfa_pkg, bitmap_page_frame_allocator and page_map_checker.
module testbench;
	import bfa_pkg::*;

	localparam int unsigned NPAGES = PAGES_DEF;
	localparam int CYCLE_LIMIT = 2500000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [ACT_W-1:0] ACT_BAD_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_BAD_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic calm = 1'b0;
	int failures;
	int pending;
	int cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitmap_page_frame_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	page_map_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.failures(failures),
		.pending(pending)
	);

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 24);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Hold the request until it is taken; idle beforehand at random.
	task automatic issue(input logic [ACT_W-1:0] act, input int unsigned first,
		input int unsigned cnt);
		req_t r;
		r.action = act;
		r.page_index = IDX_W'(first);
		r.page_count = CNT_W'(cnt);
		while (!calm && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly short runs, a few large ones, rarely more than the whole map.
	function automatic int unsigned draw_count();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 70)
			return $urandom_range(16, 1);
		else if (p < 92)
			return $urandom_range(256, 17);
		else if (p < 98)
			return $urandom_range(NPAGES, 257);
		return $urandom_range(8191, NPAGES + 1);
	endfunction

	initial begin
		int unsigned cnt;
		int unsigned first;
		int unsigned pick;
		logic [ACT_W-1:0] act;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ACT_ALLOC, 0, 0);
		issue(ACT_BAD_FIRST, 5, 3);
		issue(ACT_BAD_FIRST + 3'd1, 4095, 1);
		issue(ACT_BAD_LAST, 0, 8191);
		issue(ACT_ALLOC, 0, 1);
		// the hint sits on a busy page, so the run restarts just after it
		issue(ACT_ALLOC, 4095, 3);
		issue(ACT_LOCK, 10, 5);
		issue(ACT_RESERVE, 4090, 6);
		issue(ACT_RESERVE, 4091, 6);
		// freeing reserved pages drives the used count down to zero and holds it
		issue(ACT_FREE, 0, NPAGES);
		issue(ACT_UNRESERVE, 0, NPAGES);
		issue(ACT_RESERVE, 0, NPAGES);
		issue(ACT_ALLOC, 0, 1);
		issue(ACT_UNRESERVE, 4095, 1);
		issue(ACT_ALLOC, 0, 2);
		// hint parked at the end: even a single page cannot be found
		issue(ACT_ALLOC, 0, 1);
		issue(ACT_FREE, 4095, 1);
		issue(ACT_UNRESERVE, 0, NPAGES);
		issue(ACT_ALLOC, 0, NPAGES);
		issue(ACT_FREE, 0, NPAGES);
		issue(ACT_ALLOC, 0, NPAGES + 1);
		issue(ACT_ALLOC, 0, 8191);
		issue(ACT_LOCK, 4095, 1);
		issue(ACT_FREE, 4095, 8191);
		issue(ACT_UNRESERVE, 100, 0);
		wait_for_responses();

		for (int n = 0; n < 1625; n++) begin
			if (n == 400)
				calm <= 1'b1;
			if (n == 700)
				calm <= 1'b0;
			if (n == 900)
				wait_for_responses();
			pick = $urandom_range(99);
			cnt = draw_count();
			if (pick < 36) begin
				issue(ACT_ALLOC, $urandom_range(4095), cnt);
			end else if (pick < 88) begin
				if (pick < 58)
					act = ACT_FREE;
				else if (pick < 68)
					act = ACT_LOCK;
				else if (pick < 78)
					act = ACT_RESERVE;
				else
					act = ACT_UNRESERVE;
				if (cnt > NPAGES)
					cnt = NPAGES;
				issue(act, $urandom_range(NPAGES - cnt), cnt);
			end else if (pick < 93) begin
				issue(ACT_W'($urandom_range(ACT_BAD_LAST, ACT_BAD_FIRST)),
					$urandom_range(4095), $urandom_range(8191));
			end else if (pick < 96) begin
				issue(ACT_W'($urandom_range(ACT_UNRESERVE, ACT_ALLOC)),
					$urandom_range(4095), 0);
			end else begin
				// range running past the end of the map
				first = $urandom_range(4095, 1);
				issue(ACT_W'($urandom_range(ACT_UNRESERVE, ACT_FREE)), first,
					$urandom_range(8191, NPAGES - first + 1));
			end
		end

		wait_for_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/bfa_pkg.sv
src/bfa_ram.sv
src/bfa_word_unit.sv
src/bitmap_page_frame_allocator.sv
src/bfa_chk.sv
sim/page_map_checker.sv
sim/testbench.sv
